>>> rtl/wmf_pkg.sv
// Package for the window median filter: sizes, register indexes and the
// small compare functions shared by the column cells and the top level.
// No dependencies.
`default_nettype none
package wmf_pkg;
    localparam int PIX_W    = 16;
    localparam int CFG_W    = 11;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 11;
    localparam int POS_W    = 21;
    localparam int SLOT_W   = 2;
    localparam int ADDR_W   = SLOT_W + COL_W;
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;

    typedef logic signed [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t hi;
        pix_t md;
        pix_t lo;
    } col_t;

    typedef struct packed {
        logic prod;
        logic last;
        logic lmask;
        logic rmask;
    } flags_t;

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
        col_t r;
        r.lo = min2(min2(a, b), c);
        r.hi = max2(max2(a, b), c);
        r.md = med3(a, b, c);
        return r;
    endfunction
endpackage
`default_nettype wire

>>> rtl/wmf_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`default_nettype none
module wmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/wmf_cell.sv
// One column cell of the window: sorts the column it takes in and holds it.
// Depends on wmf_pkg.
`default_nettype none
module wmf_cell import wmf_pkg::*; (
    input  wire logic aclk,
    input  wire logic shift,
    input  wire col_t col_in,
    output col_t      col_out
);
    col_t col_reg;

    always_ff @(posedge aclk) begin
        if (shift) begin
            col_reg <= sort3(col_in.hi, col_in.md, col_in.lo);
        end
    end

    assign col_out = col_reg;
endmodule
`default_nettype wire

>>> rtl/window_median_filter_unit.sv
// Top level of the 3x3 window median filter: counters, line store, a row of
// three column cells and the median selection. Depends on wmf_pkg, wmf_ram
// and wmf_cell.
//
// Pixels enter on the s_ stream (tdata: pixel; tuser: frame_start) in raster
// order, one word per cycle. Each word reads one column of the two rows above
// it from the line store; with the new pixel that column is sorted by a cell
// and shifted along the row of three cells. The median word for pixel q leaves
// on the m_ stream (tdata: median; tlast: last pixel of the frame) when input
// position q + width + 1 has been taken, so the host sends width + 1 extra
// words after each frame. The pipeline has four register stages: the input
// register with the line store read, the column cells, the row compare
// register and the output register. Throughput is one word per cycle while
// the receiver does not stall, set by the single read of each line store copy per word.
// A stall of the receiver holds the whole pipeline and drops s_tready; a
// result waiting in the output register does not block the next word once
// it is taken. Reset clears positions and empties the pipeline; the size
// registers return to 640 by 480, and neither s_ nor cfg accepts a word
// while reset is held. The cfg channel writes width (index 0) and height
// (index 1) and is ready whenever reset is released.
`default_nettype none
module window_median_filter_unit import wmf_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [15:0]      s_tdata,   // [15:0] pixel
    input  wire logic             s_tuser,   // [0] frame_start
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [15:0]      m_tdata,   // [15:0] median
    output logic                  m_tlast,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [CFG_W-1:0] w, h;
    logic [POS_W-1:0] total, lag;
    logic [POS_W-1:0] pos_reg, pos_next, pos_cur, pos_q;
    logic [COL_W-1:0] col_reg, col_next, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur, row_m1, row_m2;
    logic             adv, accept, in_frame, top_ok, mid_ok;
    flags_t           fl0;
    flags_t           s1_flags_reg, s2_flags_reg, s3_flags_reg;
    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic             s1_top_reg, s1_mid_reg;
    pix_t             s1_pix_reg, ram_top, ram_mid;
    col_t             col_new, c0, c1, c2, lcol, rcol;
    pix_t             s3_lo_reg, s3_md_reg, s3_hi_reg;
    logic [PIX_W-1:0] out_data_reg;
    logic             out_last_reg;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
        end else if (cfg_valid) begin
            if (cfg_index == REG_WIDTH) begin
                width_reg <= cfg_data;
            end
            if (cfg_index == REG_HEIGHT) begin
                height_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        w = width_reg;
        if (width_reg == '0) begin
            w = CFG_W'(1);
        end else if (width_reg > CFG_W'(MAX_COLS)) begin
            w = CFG_W'(MAX_COLS);
        end
        h = height_reg;
        if (height_reg == '0) begin
            h = CFG_W'(1);
        end else if (height_reg > CFG_W'(MAX_ROWS)) begin
            h = CFG_W'(MAX_ROWS);
        end
    end

    assign total = POS_W'(w * h);
    assign lag   = POS_W'(w) + POS_W'(1);

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv && aresetn;
    assign accept   = s_tvalid && s_tready;

    assign pos_cur  = s_tuser ? '0 : pos_reg;
    assign col_cur  = s_tuser ? '0 : col_reg;
    assign row_cur  = s_tuser ? '0 : row_reg;
    assign row_m1   = row_cur - ROW_W'(1);
    assign row_m2   = row_cur - ROW_W'(2);
    assign pos_q    = pos_cur - lag;
    assign in_frame = pos_cur < total;
    assign top_ok   = row_cur >= ROW_W'(2);
    assign mid_ok   = (row_cur >= ROW_W'(1)) && (row_m1 < ROW_W'(h));

    always_comb begin
        fl0.prod  = (pos_cur >= lag) && (pos_q < total);
        fl0.last  = pos_q == total - POS_W'(1);
        fl0.lmask = (w == CFG_W'(1)) || (col_cur == COL_W'(1));
        fl0.rmask = col_cur == '0;
    end

    always_comb begin
        pos_next = pos_cur;
        col_next = col_cur;
        row_next = row_cur;
        if (pos_cur <= total + lag) begin
            pos_next = pos_cur + POS_W'(1);
            if (CFG_W'(col_cur) + CFG_W'(1) == w) begin
                col_next = '0;
                row_next = row_cur + ROW_W'(1);
            end else begin
                col_next = col_cur + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    wmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS * 4)) u_ram_top (
        .aclk  (aclk),
        .we    (accept && in_frame),
        .waddr ({row_cur[SLOT_W-1:0], col_cur}),
        .wdata (s_tdata),
        .re    (accept),
        .raddr ({row_m2[SLOT_W-1:0], col_cur}),
        .rdata (ram_top)
    );

    wmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS * 4)) u_ram_mid (
        .aclk  (aclk),
        .we    (accept && in_frame),
        .waddr ({row_cur[SLOT_W-1:0], col_cur}),
        .wdata (s_tdata),
        .re    (accept),
        .raddr ({row_m1[SLOT_W-1:0], col_cur}),
        .rdata (ram_mid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= accept;
        end
        if (accept) begin
            s1_pix_reg   <= in_frame ? pix_t'(s_tdata) : '0;
            s1_top_reg   <= top_ok;
            s1_mid_reg   <= mid_ok;
            s1_flags_reg <= fl0;
        end
    end

    always_comb begin
        col_new.hi = s1_pix_reg;
        col_new.md = s1_mid_reg ? ram_mid : '0;
        col_new.lo = s1_top_reg ? ram_top : '0;
    end

    wmf_cell u_cell0 (.aclk(aclk), .shift(adv && s1_valid_reg), .col_in(col_new), .col_out(c0));
    wmf_cell u_cell1 (.aclk(aclk), .shift(adv && s1_valid_reg), .col_in(c0), .col_out(c1));
    wmf_cell u_cell2 (.aclk(aclk), .shift(adv && s1_valid_reg), .col_in(c1), .col_out(c2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg && s1_flags_reg.prod;
        end
        if (adv && s1_valid_reg) begin
            s2_flags_reg <= s1_flags_reg;
        end
    end

    assign lcol = s2_flags_reg.lmask ? '0 : c2;
    assign rcol = s2_flags_reg.rmask ? '0 : c0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
        if (adv) begin
            s3_lo_reg    <= max2(max2(lcol.lo, c1.lo), rcol.lo);
            s3_md_reg    <= med3(lcol.md, c1.md, rcol.md);
            s3_hi_reg    <= min2(min2(lcol.hi, c1.hi), rcol.hi);
            s3_flags_reg <= s2_flags_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= s3_valid_reg;
        end
        if (adv) begin
            out_data_reg <= med3(s3_lo_reg, s3_md_reg, s3_hi_reg);
            out_last_reg <= s3_flags_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !s3_valid_reg)
        else $error("pipeline not empty after reset");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg && !adv |=> s3_valid_reg)
        else $error("stage lost a word during a stall");
    a_count_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_tuser && (pos_reg > total + lag) |=> $stable(pos_reg))
        else $error("position counted past frame end");
endmodule
`default_nettype wire

>>> tb/tb_window_median_filter_unit.sv
// Self-checking testbench for the 3x3 window median filter unit: frames of many
// sizes stream in with random gaps and output stalls, and each median word is
// compared with a local line-store model. Depends on wmf_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_window_median_filter_unit;
    import wmf_pkg::*;

    localparam int SLOTS       = 4;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        pix_t median;
        logic last;
    } median_word_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata = '0;    // [15:0] pixel
    logic             s_tuser = 1'b0;  // [0] frame_start
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;         // [15:0] median
    logic             m_tlast;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = REG_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;

    window_median_filter_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    pix_t         rows_mem[SLOTS][MAX_COLS];
    int unsigned  next_pos;
    logic [10:0]  width_reg;
    logic [10:0]  height_reg;
    median_word_t pending_medians[$];
    int           error_count;
    int           words_sent;
    int           medians_checked;
    int           frames_sent;
    bit           idle_on;
    int           stall_left;
    longint       cycle_count = 0;

    function automatic int unsigned eff_size(input logic [10:0] v, input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int unsigned cur_lag();
        return eff_size(width_reg, MAX_COLS) + 1;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(30, 10);
    endfunction

    // Stores the pixel and, once the lag has passed, queues the median of the
    // window centered on the pixel that is now complete.
    task automatic predict_median(input pix_t pixel, input logic frame_start);
        int unsigned w, h, total, lag, pos, q;
        int          qr, qc, r, c, k, j;
        pix_t        win[9];
        pix_t        key;
        median_word_t exp_word;
        w = eff_size(width_reg, MAX_COLS);
        h = eff_size(height_reg, MAX_ROWS);
        total = w * h;
        lag = w + 1;
        if (frame_start) next_pos = 0;
        pos = next_pos;
        if (pos < total) rows_mem[(pos / w) % SLOTS][pos % w] = pixel;
        if (pos >= lag && pos - lag < total) begin
            q = pos - lag;
            qr = q / w;
            qc = q % w;
            k = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    r = qr + dr;
                    c = qc + dc;
                    win[k] = (r >= 0 && r < h && c >= 0 && c < w) ? rows_mem[r % SLOTS][c] : '0;
                    k++;
                end
            end
            for (int i = 1; i < 9; i++) begin
                key = win[i];
                j = i - 1;
                while (j >= 0 && win[j] > key) begin
                    win[j + 1] = win[j];
                    j--;
                end
                win[j + 1] = key;
            end
            exp_word.median = win[4];
            exp_word.last = (q == total - 1);
            pending_medians.push_back(exp_word);
        end
        if (pos <= total + lag) next_pos = pos + 1;
    endtask

    task automatic send_word(input pix_t pixel, input logic frame_start);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= pixel;
        s_tuser <= frame_start;
        do @(posedge aclk); while (!s_tready);
        predict_median(pixel, frame_start);
        words_sent++;
        gap = idle_on ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        s_tuser <= 1'b0;
        while (pending_medians.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [10:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == REG_WIDTH) width_reg = value;
        else height_reg = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_size(input logic [10:0] w, input logic [10:0] h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // Pixel modes: 0 full range, 1 narrow range for many ties, 2 only the two extremes, 0 and -1.
    function automatic pix_t rand_pixel(input int mode);
        int r;
        case (mode)
            0: return pix_t'($urandom());
            1: return pix_t'($urandom_range(6)) - pix_t'(3);
            default: begin
                r = $urandom_range(3);
                return (r == 0) ? 16'sh7FFF : (r == 1) ? 16'sh8000 :
                       (r == 2) ? 16'sh0000 : 16'shFFFF;
            end
        endcase
    endfunction

    task automatic send_frame(input bit mark, input int mode, input int cut_at);
        int unsigned total, lag;
        total = eff_size(width_reg, MAX_COLS) * eff_size(height_reg, MAX_ROWS);
        lag = cur_lag();
        for (int unsigned i = 0; i < total; i++) begin
            if (cut_at >= 0 && i == cut_at) return;
            send_word(rand_pixel(mode), mark && i == 0);
        end
        for (int unsigned i = 0; i < lag; i++) send_word(pix_t'($urandom()), 1'b0);
        frames_sent++;
    endtask

    task automatic test_first_frame_unmarked();
        set_size(11'd4, 11'd3);
        send_frame(1'b0, 2, -1);
    endtask

    task automatic test_directed_extremes();
        pix_t vals[9] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
                          16'sh7FFE, 16'sh8001, 16'sh5555, 16'shAAAA};
        set_size(11'd3, 11'd3);
        for (int i = 0; i < 9; i++) send_word(vals[i], i == 0);
        for (int i = 0; i < 4; i++) send_word(pix_t'($urandom()), 1'b0);
    endtask

    task automatic test_size_clamping();
        set_size(11'd0, 11'd0);
        send_frame(1'b1, 0, -1);
        set_size(11'd0, 11'd3);
        send_frame(1'b1, 1, -1);
        set_size(11'd3, 11'd0);
        send_frame(1'b1, 2, -1);
    endtask

    task automatic test_restart_and_overrun();
        set_size(11'd5, 11'd4);
        send_frame(1'b1, 0, 13);
        send_frame(1'b1, 0, -1);
        for (int i = 0; i < 6; i++) send_word(pix_t'($urandom()), 1'b0);
        send_frame(1'b1, 1, -1);
    endtask

    task automatic test_random_frames();
        int start_words;
        start_words = words_sent;
        while (words_sent - start_words < 460) begin
            idle_on = ($urandom_range(3) != 0);
            if ($urandom_range(9) == 0) begin
                set_size(11'($urandom_range(40, 1)), 11'($urandom_range(4, 1)));
            end else begin
                set_size(11'($urandom_range(9, 1)), 11'($urandom_range(7, 1)));
            end
            send_frame(1'b1, int'($urandom_range(2)),
                       ($urandom_range(9) == 0) ? int'($urandom_range(20)) : -1);
        end
        idle_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(99) < 20) begin
            m_tready <= 1'b0;
            stall_left <= gap_len();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        median_word_t exp_word;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_medians.size() == 0) begin
                $error("Unexpected median word %0d", $signed(m_tdata));
                error_count++;
            end else begin
                exp_word = pending_medians.pop_front();
                medians_checked++;
                if (pix_t'(m_tdata) !== exp_word.median) begin
                    $error("median: expected %0d, got %0d", exp_word.median, $signed(m_tdata));
                    error_count++;
                end
                if (m_tlast !== exp_word.last) begin
                    $error("last: expected %0b, got %0b", exp_word.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        next_pos = 0;
        width_reg = 11'd640;
        height_reg = 11'd480;
        error_count = 0;
        words_sent = 0;
        medians_checked = 0;
        frames_sent = 0;
        idle_on = 1'b1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_first_frame_unmarked();
        test_directed_extremes();
        test_size_clamping();
        test_restart_and_overrun();
        test_random_frames();
        drain();
        if (pending_medians.size() != 0) begin
            $error("%0d expected medians never arrived", pending_medians.size());
            error_count++;
        end
        $display("Sent %0d pixel words in %0d complete frames, checked %0d medians.",
                 words_sent, frames_sent, medians_checked);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire
